/* sv/sbeq_pkg.sv */
// ----------------------------------------------------------------------------
// sbeq_pkg
// Shared constants, payload types, register codes and controller/datapath
// command types for the stereo three-band biquad equalizer.
// ----------------------------------------------------------------------------
package sbeq_pkg;

	// Fixed formats of samples and coefficients
	localparam int SAMPLE_BITS        = 24;
	localparam int COEF_BITS          = 20;
	localparam int COEF_FRACTION_BITS = 16;

	// Defaults for the top level parameters
	localparam int DEF_DELAY_BITS = 40;
	localparam int DEF_SECTIONS   = 3;

	// Register file: one feedforward and one feedback register per band
	localparam int BANDS      = 3;
	localparam int BAND_IDX_W = 2;
	localparam int FF_W       = 3 * COEF_BITS;
	localparam int FB_W       = 2 * COEF_BITS;
	localparam int REG_COUNT  = 7;
	localparam int DATA_W     = 64;
	localparam int ADDR_W     = $clog2(REG_COUNT * 8);
	localparam int REG_IDX_W  = ADDR_W - 3;

	typedef logic [FF_W-1:0] ff_reg_t;
	typedef logic [FB_W-1:0] fb_reg_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BYPASS,
		REG_LOW_FF,
		REG_LOW_FB,
		REG_PEAK_FF,
		REG_PEAK_FB,
		REG_HIGH_FF,
		REG_HIGH_FB
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
	} sample_pair_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_result;
		logic signed [SAMPLE_BITS-1:0] right_result;
	} result_pair_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B0,
		ST_Y,
		ST_Z1A,
		ST_Z1B,
		ST_Z2A,
		ST_Z2B,
		ST_SWAP,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_B0,
		OP_Y,
		OP_Z1A,
		OP_Z1B,
		OP_Z2A,
		OP_Z2B,
		OP_SWAP,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t                op;
		logic                  ch;
		logic [BAND_IDX_W-1:0] sec;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

/* sv/sbeq_regs.sv */
// ----------------------------------------------------------------------------
// sbeq_regs
// APB register file: bypass flag and the packed biquad coefficients.
// A coefficient write pulses clear so that all delay state is zeroed.
// ----------------------------------------------------------------------------
module sbeq_regs
	import sbeq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   bypass,
	output ff_reg_t [BANDS-1:0]    ff,
	output fb_reg_t [BANDS-1:0]    fb,
	output logic                   coef_clear
);

	logic                  bypass_q;
	ff_reg_t [BANDS-1:0]   ff_q;
	fb_reg_t [BANDS-1:0]   fb_q;
	logic                  wr;
	reg_idx_t              idx;

	assign wr  = psel & penable & pwrite;
	assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_comb begin
		unique case (idx) inside
			REG_LOW_FF, REG_LOW_FB, REG_PEAK_FF, REG_PEAK_FB, REG_HIGH_FF, REG_HIGH_FB: begin
				coef_clear = wr;
			end
			default: begin
				coef_clear = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b1;
			ff_q     <= '0;
			fb_q     <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_BYPASS:  bypass_q <= pwdata[0];
				REG_LOW_FF:  ff_q[0]  <= pwdata[FF_W-1:0];
				REG_LOW_FB:  fb_q[0]  <= pwdata[FB_W-1:0];
				REG_PEAK_FF: ff_q[1]  <= pwdata[FF_W-1:0];
				REG_PEAK_FB: fb_q[1]  <= pwdata[FB_W-1:0];
				REG_HIGH_FF: ff_q[2]  <= pwdata[FF_W-1:0];
				REG_HIGH_FB: fb_q[2]  <= pwdata[FB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BYPASS:  prdata = DATA_W'(bypass_q);
			REG_LOW_FF:  prdata = DATA_W'(ff_q[0]);
			REG_LOW_FB:  prdata = DATA_W'(fb_q[0]);
			REG_PEAK_FF: prdata = DATA_W'(ff_q[1]);
			REG_PEAK_FB: prdata = DATA_W'(fb_q[1]);
			REG_HIGH_FF: prdata = DATA_W'(ff_q[2]);
			REG_HIGH_FB: prdata = DATA_W'(fb_q[2]);
			default:     prdata = '0;
		endcase
	end

	assign bypass = bypass_q;
	assign ff     = ff_q;
	assign fb     = fb_q;

endmodule

/* sv/sbeq_ctrl.sv */
// ----------------------------------------------------------------------------
// sbeq_ctrl
// Sequencer: steps each channel through the biquad sections unless bypassed,
// six datapath ops per section, then hands the pair to the output register.
// ----------------------------------------------------------------------------
module sbeq_ctrl
	import sbeq_pkg::*;
#(
	parameter int SECTIONS = DEF_SECTIONS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	input  logic       bypass,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [BAND_IDX_W-1:0] LAST_SEC = BAND_IDX_W'(SECTIONS - 1);

	ctrl_state_t           state_q, state_nxt;
	logic                  ch_q;
	logic [BAND_IDX_W-1:0] sec_q;
	logic                  last_sec;

	assign last_sec = (sec_q == LAST_SEC);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_nxt = bypass ? ST_SWAP : ST_B0;
				end
			end
			ST_B0:  state_nxt = ST_Y;
			ST_Y:   state_nxt = ST_Z1A;
			ST_Z1A: state_nxt = ST_Z1B;
			ST_Z1B: state_nxt = ST_Z2A;
			ST_Z2A: state_nxt = ST_Z2B;
			ST_Z2B: begin
				if (!last_sec) begin
					state_nxt = ST_B0;
				end else begin
					state_nxt = ch_q ? ST_DONE : ST_SWAP;
				end
			end
			ST_SWAP: state_nxt = bypass ? ST_DONE : ST_B0;
			ST_DONE: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.ch       = ch_q;
		cmd.sec      = sec_q;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				cmd.op       = sample_valid ? OP_LOAD : OP_NONE;
			end
			ST_B0:   cmd.op = OP_B0;
			ST_Y:    cmd.op = OP_Y;
			ST_Z1A:  cmd.op = OP_Z1A;
			ST_Z1B:  cmd.op = OP_Z1B;
			ST_Z2A:  cmd.op = OP_Z2A;
			ST_Z2B:  cmd.op = OP_Z2B;
			ST_SWAP: cmd.op = OP_SWAP;
			ST_DONE: cmd.op = status.out_free ? OP_OUT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= 1'b0;
			sec_q   <= '0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_IDLE: begin
					ch_q  <= 1'b0;
					sec_q <= '0;
				end
				ST_Z2B: begin
					if (!last_sec) begin
						sec_q <= sec_q + 1'b1;
					end
				end
				ST_SWAP: begin
					ch_q  <= 1'b1;
					sec_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

/* sv/sbeq_dp.sv */
// ----------------------------------------------------------------------------
// sbeq_dp
// Datapath: one shared signed multiplier with a registered product, an
// accumulator, the per-channel delay registers and the output register.
// ----------------------------------------------------------------------------
module sbeq_dp
	import sbeq_pkg::*;
#(
	parameter int SECTIONS   = DEF_SECTIONS,
	parameter int DELAY_BITS = DEF_DELAY_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	input  ff_reg_t [BANDS-1:0] ff,
	input  fb_reg_t [BANDS-1:0] fb,
	input  logic                coef_clear,
	input  sample_pair_t        sample,
	output logic                result_valid,
	input  logic                result_stall,
	output result_pair_t        result
);

	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
	localparam int MAX_W  = (PROD_W > DELAY_BITS) ? PROD_W : DELAY_BITS;
	localparam int ACC_W  = MAX_W + 2;
	localparam int DEPTH  = 2 * SECTIONS;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int F      = COEF_FRACTION_BITS;

	localparam logic signed [ACC_W-1:0] Y_HI =
		{{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] Y_LO = ~Y_HI;
	localparam logic signed [ACC_W-1:0] D_HI =
		{{(ACC_W - DELAY_BITS + 1){1'b0}}, {(DELAY_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] D_LO = ~D_HI;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);

	logic signed [DELAY_BITS-1:0]  z1_q [DEPTH];
	logic signed [DELAY_BITS-1:0]  z2_q [DEPTH];
	logic signed [SAMPLE_BITS-1:0] x_q, y_q, right_q, left_res_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       t_q;
	result_pair_t                  result_q;
	logic                          result_valid_q;

	logic [IDX_W-1:0]              idx;
	ff_reg_t                       ff_sel;
	fb_reg_t                       fb_sel;
	logic signed [COEF_BITS-1:0]   mul_coef;
	logic signed [SAMPLE_BITS-1:0] mul_data;
	logic signed [ACC_W-1:0]       acc_y, shifted, diff;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [DELAY_BITS-1:0]  d_sat;

	assign idx    = IDX_W'(cmd.sec) + (cmd.ch ? IDX_W'(SECTIONS) : IDX_W'(0));
	assign ff_sel = ff[cmd.sec];
	assign fb_sel = fb[cmd.sec];

	// operand selection for the shared multiplier
	always_comb begin
		mul_data = x_q;
		case (cmd.op)
			OP_B0:   mul_coef = ff_sel[0 +: COEF_BITS];
			OP_Y:    mul_coef = ff_sel[COEF_BITS +: COEF_BITS];
			OP_Z1A: begin
				mul_coef = fb_sel[0 +: COEF_BITS];
				mul_data = y_q;
			end
			OP_Z1B:  mul_coef = ff_sel[2*COEF_BITS +: COEF_BITS];
			OP_Z2A: begin
				mul_coef = fb_sel[COEF_BITS +: COEF_BITS];
				mul_data = y_q;
			end
			default: mul_coef = '0;
		endcase
	end

	// section output: round half up, floor shift, saturate to sample range
	always_comb begin
		acc_y   = ACC_W'(prod_q) + ACC_W'(z1_q[idx]) + HALF;
		shifted = acc_y >>> F;
		if (shifted > Y_HI) begin
			y_sat = Y_HI[SAMPLE_BITS-1:0];
		end else if (shifted < Y_LO) begin
			y_sat = Y_LO[SAMPLE_BITS-1:0];
		end else begin
			y_sat = shifted[SAMPLE_BITS-1:0];
		end
	end

	// delay update: partial sum minus feedback product, saturated
	always_comb begin
		diff = t_q - ACC_W'(prod_q);
		if (diff > D_HI) begin
			d_sat = D_HI[DELAY_BITS-1:0];
		end else if (diff < D_LO) begin
			d_sat = D_LO[DELAY_BITS-1:0];
		end else begin
			d_sat = diff[DELAY_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_coef * mul_data;
		case (cmd.op)
			OP_LOAD: begin
				x_q     <= sample.left_sample;
				right_q <= sample.right_sample;
			end
			OP_Y:    y_q <= y_sat;
			OP_Z1A:  t_q <= ACC_W'(prod_q) + ACC_W'(z2_q[idx]);
			OP_Z2A:  t_q <= ACC_W'(prod_q);
			OP_Z2B:  x_q <= y_q;
			OP_SWAP: begin
				left_res_q <= x_q;
				x_q        <= right_q;
			end
			OP_OUT: begin
				result_q.left_result  <= left_res_q;
				result_q.right_result <= x_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				z1_q[i] <= '0;
				z2_q[i] <= '0;
			end
		end else if (coef_clear) begin
			for (int i = 0; i < DEPTH; i++) begin
				z1_q[i] <= '0;
				z2_q[i] <= '0;
			end
		end else if (cmd.op == OP_Z1B) begin
			z1_q[idx] <= d_sat;
		end else if (cmd.op == OP_Z2B) begin
			z2_q[idx] <= d_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !result_valid_q || !result_stall;
	assign result_valid    = result_valid_q;
	assign result          = result_q;

endmodule

/* sv/stereo_three_band_biquad_equalizer_unit.sv */
// ----------------------------------------------------------------------------
// stereo_three_band_biquad_equalizer_unit
// Stereo equalizer: three transposed direct form II biquads per channel.
// ----------------------------------------------------------------------------
// One stereo pair is taken at a time. With the equalizer on, every section
// of every channel runs on the single shared coefficient-by-sample
// multiplier, which produces the five products of that section. In bypass
// a pair skips the sections. A finished pair sits in the output register,
// so the next pair is taken while it waits. Writing any coefficient register
// zeroes all delay state at once; program registers only while no transfer
// is in progress.
module stereo_three_band_biquad_equalizer_unit
	import sbeq_pkg::*;
#(
	parameter int SECTIONS   = DEF_SECTIONS,
	parameter int DELAY_BITS = DEF_DELAY_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_pair_t      sample,
	output logic              result_valid,
	input  logic              result_stall,
	output result_pair_t      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic                bypass;
	logic                coef_clear;
	ff_reg_t [BANDS-1:0] ff;
	fb_reg_t [BANDS-1:0] fb;
	dp_cmd_t             cmd;
	dp_status_t          status;

	assign pready = 1'b1;

	sbeq_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.bypass     (bypass),
		.ff         (ff),
		.fb         (fb),
		.coef_clear (coef_clear)
	);

	sbeq_ctrl #(
		.SECTIONS (SECTIONS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.bypass       (bypass),
		.status       (status),
		.cmd          (cmd)
	);

	sbeq_dp #(
		.SECTIONS   (SECTIONS),
		.DELAY_BITS (DELAY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.ff           (ff),
		.fb           (fb),
		.coef_clear   (coef_clear),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* sv/sbeq_checker.sv */
// ----------------------------------------------------------------------------
// sbeq_checker
// Port-level checks of the equalizer, bound to the top level.
// ----------------------------------------------------------------------------
module sbeq_checker
	import sbeq_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         sample_valid,
	input logic         sample_stall,
	input logic         result_valid,
	input logic         result_stall,
	input result_pair_t result
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one pair at a time: after a transfer in, the input is stalled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("input not stalled after transfer");

	// a new result only comes out of a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result appeared without work in progress");

endmodule

bind stereo_three_band_biquad_equalizer_unit sbeq_checker u_sbeq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo three-band biquad equalizer unit.
// ----------------------------------------------------------------------------
// Pairs queued by the stimulus process are sent by a clocked driver. At each
// accepted transfer the driver runs a shadow of the three biquad bands and
// stores the expected pair. A clocked monitor compares every result transfer
// with the oldest stored pair. Registers are written over APB only while the
// unit is idle, then read back. The test starts with directed cases (bypass,
// unity gain, saturating coefficients, bypass with delays held, clearing
// writes) and then runs random phases with random settings.
// ----------------------------------------------------------------------------
module testbench;
	import sbeq_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int SETTLE_CYCLES    = 8;
	localparam int PHASE_PAIRS      = 225;
	localparam int RANDOM_PHASES    = 8;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int UNUSED_REG_IDX   = REG_COUNT;

	localparam int STYLE_TAME = 0;
	localparam int STYLE_WILD = 1;
	localparam int STYLE_EDGE = 2;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam logic [COEF_BITS-1:0]   COEF_UNITY = COEF_BITS'(1 << COEF_FRACTION_BITS);
	localparam longint                 ROUND_HALF = longint'(1) <<< (COEF_FRACTION_BITS - 1);

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	sample_pair_t      sample       = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_pair_t      result;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// shadow of the register file and of the delay lines
	logic [DATA_W-1:0] reg_shadow [REG_COUNT];
	longint            first_state [2][DEF_SECTIONS];
	longint            second_state [2][DEF_SECTIONS];

	sample_pair_t pairs_to_send [$];
	result_pair_t equalized_q [$];

	int  mismatch_count  = 0;
	int  send_gap        = 0;
	int  stall_left      = 0;
	int  free_left       = 0;
	int  hold_left       = 0;
	int  hold_requests   = 0;
	int  holds_started   = 0;
	bit  gapless_sender  = 1'b0;
	bit  steady_receiver = 1'b0;

	stereo_three_band_biquad_equalizer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint clamp_signed(longint v, int bits);
		longint top;
		top = (longint'(1) <<< (bits - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	function automatic longint coef_at(logic [DATA_W-1:0] word, int k);
		logic signed [COEF_BITS-1:0] c;
		c = word[k*COEF_BITS +: COEF_BITS];
		return longint'(c);
	endfunction

	function automatic void clear_delay_state();
		for (int ch = 0; ch < 2; ch++)
			for (int band = 0; band < DEF_SECTIONS; band++) begin
				first_state[ch][band]  = 0;
				second_state[ch][band] = 0;
			end
	endfunction

	// one stereo pair through the band cascade, updating the shadow delays
	function automatic result_pair_t equalize_pair(sample_pair_t s);
		result_pair_t r;
		longint       x [2];
		longint       b0, b1, b2, a1, a2, acc;
		x[0] = longint'($signed(s.left_sample));
		x[1] = longint'($signed(s.right_sample));
		if (!reg_shadow[REG_BYPASS][0]) begin
			for (int ch = 0; ch < 2; ch++)
				for (int band = 0; band < DEF_SECTIONS; band++) begin
					b0  = coef_at(reg_shadow[REG_LOW_FF + 2*band], 0);
					b1  = coef_at(reg_shadow[REG_LOW_FF + 2*band], 1);
					b2  = coef_at(reg_shadow[REG_LOW_FF + 2*band], 2);
					a1  = coef_at(reg_shadow[REG_LOW_FB + 2*band], 0);
					a2  = coef_at(reg_shadow[REG_LOW_FB + 2*band], 1);
					acc = b0 * x[ch] + first_state[ch][band];
					acc = clamp_signed((acc + ROUND_HALF) >>> COEF_FRACTION_BITS,
						SAMPLE_BITS);
					first_state[ch][band] = clamp_signed(b1 * x[ch] - a1 * acc +
						second_state[ch][band], DEF_DELAY_BITS);
					second_state[ch][band] = clamp_signed(b2 * x[ch] - a2 * acc,
						DEF_DELAY_BITS);
					x[ch] = acc;
				end
		end
		r.left_result  = SAMPLE_BITS'(x[0]);
		r.right_result = SAMPLE_BITS'(x[1]);
		return r;
	endfunction

	// mostly short idles, now and then a long one
	function automatic int pick_idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 100);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			1: return $urandom_range(0, 1) ? SAMPLE_BITS'(0) : SAMPLE_BITS'(-1);
			2, 3: return SAMPLE_BITS'($urandom_range(0, 4096) - 2048);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [COEF_BITS-1:0] pick_coef(int style, int limit);
		case (style)
			STYLE_TAME: return COEF_BITS'($urandom_range(0, 2 * limit) - limit);
			STYLE_WILD: return COEF_BITS'($urandom());
			default: begin
				case ($urandom_range(0, 5))
					0: return COEF_MAX;
					1: return COEF_MIN;
					2: return COEF_BITS'(0);
					3: return COEF_UNITY;
					4: return COEF_BITS'(-(1 << COEF_FRACTION_BITS));
					default: return COEF_BITS'($urandom());
				endcase
			end
		endcase
	endfunction

	task automatic push_pair(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r);
		sample_pair_t p;
		p.left_sample  = l;
		p.right_sample = r;
		pairs_to_send.push_back(p);
	endtask

	// returns once every queued pair has gone and every result has come back
	task automatic wait_idle();
		@(negedge clk);
		while (pairs_to_send.size() != 0 || sample_valid || equalized_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [DATA_W-1:0] word);
		logic [DATA_W-1:0] readback;
		reg_idx_t          which;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 8);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_BYPASS) begin
			reg_shadow[idx] = word & DATA_W'(1);
		end else if (idx < REG_COUNT) begin
			reg_shadow[idx] = word & ((DATA_W'(1) << ((idx % 2) ? FF_W : FB_W)) - 1);
			clear_delay_state();
		end
		if (idx < REG_COUNT) begin
			@(posedge clk);
			psel <= 1'b1;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			readback = prdata;
			psel    <= 1'b0;
			penable <= 1'b0;
			if (readback !== reg_shadow[idx]) begin
				which = reg_idx_t'(idx);
				$error("%s: expected %0h, got %0h", which.name(), reg_shadow[idx], readback);
				mismatch_count++;
			end
		end
	endtask

	// sender: a new pair goes out once the previous transfer is done
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
			send_gap = 0;
		end else begin
			if (sample_valid && !sample_stall)
				equalized_q.push_back(equalize_pair(sample));
			if (!sample_valid || !sample_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pairs_to_send.size() > 0) begin
					sample       <= pairs_to_send.pop_front();
					sample_valid <= 1'b1;
					send_gap = gapless_sender ? 0 : pick_idle_length();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result transfer and drives random stalls
	always @(posedge clk or negedge arst_n) begin
		result_pair_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
			free_left  = 0;
			hold_left  = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (equalized_q.size() == 0) begin
					$error("result transfer with no expected pair outstanding");
					mismatch_count++;
				end else begin
					want = equalized_q.pop_front();
					if (result.left_result !== want.left_result) begin
						$error("left_result: expected %0d, got %0d",
							want.left_result, result.left_result);
						mismatch_count++;
					end
					if (result.right_result !== want.right_result) begin
						$error("right_result: expected %0d, got %0d",
							want.right_result, result.right_result);
						mismatch_count++;
					end
				end
			end
			if (holds_started != hold_requests) begin
				holds_started++;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (steady_receiver) begin
				result_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				result_stall <= 1'b0;
			end else begin
				free_left  = $urandom_range(0, 12);
				stall_left = pick_idle_length();
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		int                phase, k, band, style;
		logic [DATA_W-1:0] word;
		reg_shadow[REG_BYPASS] = DATA_W'(1);
		for (k = 1; k < REG_COUNT; k++)
			reg_shadow[k] = '0;
		clear_delay_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// bypass out of reset
		@(negedge clk);
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		push_pair(SAMPLE_MIN, SAMPLE_MAX);
		push_pair(SAMPLE_BITS'(0), SAMPLE_BITS'(-1));
		push_pair(SAMPLE_BITS'(-1), SAMPLE_BITS'(0));
		push_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(24'h555555));
		wait_idle();

		// unity gain in every band, plus a write to an unmapped address
		for (band = 0; band < BANDS; band++) begin
			write_reg(REG_LOW_FF + 2*band, DATA_W'(COEF_UNITY));
			write_reg(REG_LOW_FB + 2*band, '0);
		end
		write_reg(REG_BYPASS, '0);
		write_reg(UNUSED_REG_IDX, '1);
		@(negedge clk);
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		push_pair(SAMPLE_MIN, SAMPLE_MAX);
		push_pair(SAMPLE_BITS'(24'h123456), SAMPLE_BITS'(24'hABCDEF));
		wait_idle();

		// full-scale coefficients: section outputs and delays saturate;
		// the upper bits of each write must be dropped
		for (band = 0; band < BANDS; band++) begin
			write_reg(REG_LOW_FF + 2*band, {4'hF, COEF_MAX, COEF_MIN, COEF_MAX});
			write_reg(REG_LOW_FB + 2*band, {24'hFFFFFF, COEF_MIN, COEF_MAX});
		end
		@(negedge clk);
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		push_pair(SAMPLE_MAX, SAMPLE_MAX);
		push_pair(SAMPLE_MIN, SAMPLE_MIN);
		push_pair(SAMPLE_BITS'(0), SAMPLE_BITS'(0));
		push_pair(SAMPLE_MIN, SAMPLE_MAX);
		push_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(-1));
		wait_idle();

		// bypass on and off again keeps the delay lines
		write_reg(REG_BYPASS, '1);
		@(negedge clk);
		push_pair(SAMPLE_MAX, SAMPLE_BITS'(-2));
		wait_idle();
		write_reg(REG_BYPASS, ~DATA_W'(1));
		@(negedge clk);
		push_pair(SAMPLE_BITS'(1000), SAMPLE_BITS'(-1000));
		push_pair(SAMPLE_BITS'(0), SAMPLE_BITS'(0));
		wait_idle();

		// any coefficient write clears the delay lines
		write_reg(REG_HIGH_FB, '0);
		@(negedge clk);
		push_pair(SAMPLE_BITS'(0), SAMPLE_BITS'(0));
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		wait_idle();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			style = ($urandom_range(0, 9) < 6) ? STYLE_TAME :
				($urandom_range(0, 1) ? STYLE_WILD : STYLE_EDGE);
			for (band = 0; band < BANDS; band++) begin
				if (phase == 0 || $urandom_range(0, 3) != 0)
					write_reg(REG_LOW_FF + 2*band, {4'($urandom()),
						pick_coef(style, 65536), pick_coef(style, 65536),
						pick_coef(style, 65536)});
				if (phase == 0 || $urandom_range(0, 3) != 0)
					write_reg(REG_LOW_FB + 2*band, {24'($urandom()),
						pick_coef(style, 16384), pick_coef(style, 32768)});
			end
			if ($urandom_range(0, 4) == 0)
				write_reg(UNUSED_REG_IDX, {$urandom(), $urandom()});
			word    = {$urandom(), $urandom()};
			word[0] = ($urandom_range(0, 4) == 0);
			write_reg(REG_BYPASS, word);

			@(negedge clk);
			gapless_sender  = (phase == 2 || phase == 6);
			steady_receiver = (phase == 3 || phase == 6);
			// the receiver holds off while the sender keeps offering
			if (phase == 1 || phase == 4)
				hold_requests++;
			for (k = 0; k < PHASE_PAIRS; k++)
				push_pair(pick_sample(), pick_sample());
			wait_idle();
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && equalized_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#25ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
